// ===== hdl/tga_pkg.sv =====
// shared types and constants of the tga stream decoder
package tga_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // header layout
   localparam logic [4:0] HDR_TYPE      = 5'd2;
   localparam logic [4:0] HDR_FIXED_END = 5'd12;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;

   // header values
   localparam logic [7:0] TYPE_RAW = 8'h02;
   localparam logic [7:0] TYPE_RLE = 8'h0A;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   // largest run length of one packet
   localparam logic [7:0] MAX_RUN = 8'd128;

   typedef enum logic [4:0] {
      PH_WAIT    = 5'b00001,
      PH_HEADER  = 5'b00010,
      PH_PACKET  = 5'b00100,
      PH_LITERAL = 5'b01000,
      PH_RUN     = 5'b10000
   } tga_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } tga_beat_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        four_byte_pixels;
      logic        is_compressed;
      logic        image_done;
   } tga_result_type;

endpackage

// ===== hdl/tga_stream_decoder_top.sv =====
// top level of the tga stream decoder
//
// takes a tga file one byte per beat on the req_ channel; req_frame_start
// marks header byte 0 of a new file and may abandon an image in progress
// after the 18-byte header one header-info result gives width, height,
// depth and compression, or a format error result is sent at the first bad
// header byte; then each raw pixel gives one pixel result and each run
// packet gives one result with its repeat count, clipped to the pixels left
// the result that finishes the image carries rsp_image_done
// bytes outside a frame are dropped without a result
// path: an accepted beat is held in the input register and decoded out of
// it, and its result, if any, is loaded into the result register, which
// drives rsp_valid
// throughput: one byte per cycle unless a result stalls, set by the single
// decode pass between the input register and the result register; the
// header multiply of width by height sits in that pass
// reset: the decoder waits for a frame start, both registers are empty
// stall: a held result stays in the result register; one more beat can wait
// in the input register, and req_ready drops only when both are full
module tga_stream_decoder_top
   import tga_pkg::*;
#(
   parameter int DIM_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_pixel_value,
   output logic [7:0]  rsp_repeat_count,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic        rsp_four_byte_pixels,
   output logic        rsp_is_compressed,
   output logic        rsp_image_done
);

   tga_beat_type   req_beat;
   tga_beat_type   beat;
   logic           beat_valid;
   logic           advance;
   logic           dec_valid;
   tga_result_type dec_result;
   tga_result_type rsp_result;

   assign req_beat.data_byte   = req_data_byte;
   assign req_beat.frame_start = req_frame_start;

   // a held byte is decoded when the result register is free or draining
   assign advance = beat_valid && (!rsp_valid || rsp_ready);

   tga_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_beat   (req_beat),
      .pop        (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   tga_decode #(
      .DIM_BITS (DIM_BITS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .beat      (beat),
      .res_valid (dec_valid),
      .res       (dec_result)
   );

   tga_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .load_valid  (dec_valid),
      .load_result (dec_result),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_result  (rsp_result)
   );

   assign rsp_result_kind      = rsp_result.result_kind;
   assign rsp_pixel_value      = rsp_result.pixel_value;
   assign rsp_repeat_count     = rsp_result.repeat_count;
   assign rsp_image_width      = rsp_result.image_width;
   assign rsp_image_height     = rsp_result.image_height;
   assign rsp_four_byte_pixels = rsp_result.four_byte_pixels;
   assign rsp_is_compressed    = rsp_result.is_compressed;
   assign rsp_image_done       = rsp_result.image_done;

   // a byte waiting on a stalled result is not lost or changed
   a_held_beat_kept: assert property (@(posedge clock) disable iff (reset)
      beat_valid && !advance |=> beat_valid && $stable(beat))
      else $error("input beat dropped or changed while stalled");

   // error results carry nothing but their kind
   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_ERROR)
      |-> (rsp_pixel_value == 32'd0) && (rsp_repeat_count == 8'd0)
          && (rsp_image_width == 16'd0) && (rsp_image_height == 16'd0)
          && !rsp_four_byte_pixels && !rsp_is_compressed && !rsp_image_done)
      else $error("format error result with nonzero fields");

   // an empty input register always takes a beat
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !beat_valid |-> req_ready)
      else $error("input refused while input register empty");

endmodule

// ===== hdl/tga_in_reg.sv =====
// input register stage holding one accepted byte beat
module tga_in_reg
   import tga_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  tga_beat_type req_beat,
   input  logic         pop,
   output logic         beat_valid,
   output tga_beat_type beat
);

   logic         valid_ff, valid_in;
   tga_beat_type beat_ff, beat_in;

   assign req_ready = !valid_ff || pop;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (req_ready) begin
         valid_in = req_valid;
         beat_in  = req_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

// ===== hdl/tga_decode.sv =====
// header check, packet parsing and pixel assembly, one byte per step
module tga_decode
   import tga_pkg::*;
#(
   parameter int DIM_BITS = 16
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  tga_beat_type   beat,
   output logic           res_valid,
   output tga_result_type res
);

   localparam int PL_W = 2 * DIM_BITS;
   localparam logic [16:0] MAX_DIM = 17'((1 << DIM_BITS) - 1);

   tga_phase_type   phase_ff, phase_in;
   logic [4:0]      hidx_ff, hidx_in;
   logic            comp_ff, comp_in;
   logic            depth_ff, depth_in;
   logic [15:0]     width_ff, width_in;
   logic [15:0]     height_ff, height_in;
   logic [PL_W-1:0] pl_ff, pl_in;
   logic [7:0]      pkt_ff, pkt_in;
   logic [1:0]      bip_ff, bip_in;
   logic [31:0]     asm_ff, asm_in;

   tga_phase_type   cur_phase;
   logic [4:0]      cur_hidx;
   logic [1:0]      cur_bip;
   logic [7:0]      cur_pkt;
   logic [PL_W-1:0] cur_pl;
   logic [7:0]      b;
   logic [31:0]     pix_asm;
   logic            pix_done;
   logic [1:0]      last_k;
   logic [PL_W-1:0] area;
   logic            area_zero;
   logic            dim_bad;
   logic [7:0]      run_rep;
   logic [7:0]      rep_sel;
   logic [PL_W-1:0] pl_next;
   logic [7:0]      pkt_dec;

   always_comb begin
      b         = beat.data_byte;
      cur_phase = beat.frame_start ? PH_HEADER : phase_ff;
      cur_hidx  = beat.frame_start ? 5'd0 : hidx_ff;
      cur_bip   = beat.frame_start ? 2'd0 : bip_ff;
      cur_pkt   = beat.frame_start ? 8'd0 : pkt_ff;
      cur_pl    = beat.frame_start ? '0 : pl_ff;

      // pixel byte assembly
      last_k   = depth_ff ? 2'd3 : 2'd2;
      pix_asm  = (cur_bip == 2'd0) ? {24'd0, b} : (asm_ff | ({24'd0, b} << {cur_bip, 3'b000}));
      pix_done = (cur_bip >= last_k);

      // image size
      area      = PL_W'(width_ff[DIM_BITS-1:0]) * PL_W'(height_ff[DIM_BITS-1:0]);
      area_zero = (width_ff == 16'd0) || (height_ff == 16'd0);
      dim_bad   = ({1'b0, width_ff} > MAX_DIM) || ({1'b0, height_ff} > MAX_DIM);

      // run clipped to remaining pixels
      run_rep = (cur_pl < PL_W'(cur_pkt)) ? cur_pl[7:0] : cur_pkt;
      rep_sel = (cur_phase == PH_RUN) ? run_rep : 8'd1;
      pl_next = cur_pl - PL_W'(rep_sel);
      pkt_dec = cur_pkt - 8'd1;

      phase_in  = cur_phase;
      hidx_in   = cur_hidx;
      comp_in   = comp_ff;
      depth_in  = depth_ff;
      width_in  = width_ff;
      height_in = height_ff;
      pl_in     = cur_pl;
      pkt_in    = cur_pkt;
      bip_in    = cur_bip;
      asm_in    = asm_ff;

      res_valid = 1'b0;
      res       = '0;

      case (cur_phase)
         PH_HEADER: begin
            hidx_in = cur_hidx + 5'd1;
            if (cur_hidx == HDR_TYPE) begin
               if (b == TYPE_RAW) begin
                  comp_in = 1'b0;
               end else if (b == TYPE_RLE) begin
                  comp_in = 1'b1;
               end else begin
                  phase_in        = PH_WAIT;
                  res_valid       = 1'b1;
                  res.result_kind = KIND_ERROR;
               end
            end else if (cur_hidx < HDR_FIXED_END) begin
               if (b != 8'd0) begin
                  phase_in        = PH_WAIT;
                  res_valid       = 1'b1;
                  res.result_kind = KIND_ERROR;
               end
            end else if (cur_hidx == HDR_WIDTH_LO) begin
               width_in = {width_ff[15:8], b};
            end else if (cur_hidx == HDR_WIDTH_HI) begin
               width_in = {b, width_ff[7:0]};
            end else if (cur_hidx == HDR_HEIGHT_LO) begin
               height_in = {height_ff[15:8], b};
            end else if (cur_hidx == HDR_HEIGHT_HI) begin
               height_in = {b, height_ff[7:0]};
            end else if (cur_hidx == HDR_DEPTH) begin
               if (b == DEPTH_24) begin
                  depth_in = 1'b0;
               end else if (b == DEPTH_32) begin
                  depth_in = 1'b1;
               end else begin
                  phase_in        = PH_WAIT;
                  res_valid       = 1'b1;
                  res.result_kind = KIND_ERROR;
               end
            end else begin
               // descriptor byte closes the header
               res_valid = 1'b1;
               if (dim_bad) begin
                  phase_in        = PH_WAIT;
                  res.result_kind = KIND_ERROR;
               end else begin
                  pl_in  = area;
                  bip_in = 2'd0;
                  pkt_in = 8'd0;
                  if (area_zero) begin
                     phase_in = PH_WAIT;
                  end else begin
                     phase_in = comp_ff ? PH_PACKET : PH_LITERAL;
                  end
                  res.result_kind      = KIND_HEADER;
                  res.image_width      = width_ff;
                  res.image_height     = height_ff;
                  res.four_byte_pixels = depth_ff;
                  res.is_compressed    = comp_ff;
                  res.image_done       = area_zero;
               end
            end
         end
         PH_PACKET: begin
            // both packet kinds carry count minus one in the low seven bits
            bip_in   = 2'd0;
            pkt_in   = {1'b0, b[6:0]} + 8'd1;
            phase_in = b[7] ? PH_RUN : PH_LITERAL;
         end
         PH_LITERAL, PH_RUN: begin
            asm_in = pix_asm;
            bip_in = pix_done ? 2'd0 : cur_bip + 2'd1;
            if (pix_done) begin
               pl_in                = pl_next;
               res_valid            = 1'b1;
               res.result_kind      = KIND_PIXEL;
               res.pixel_value      = pix_asm;
               res.repeat_count     = rep_sel;
               res.image_width      = width_ff;
               res.image_height     = height_ff;
               res.four_byte_pixels = depth_ff;
               res.is_compressed    = comp_ff;
               res.image_done       = (pl_next == '0);
               if (cur_phase == PH_RUN) begin
                  pkt_in   = 8'd0;
                  phase_in = (pl_next == '0) ? PH_WAIT : PH_PACKET;
               end else if (pl_next == '0) begin
                  phase_in = PH_WAIT;
               end else if (comp_ff) begin
                  pkt_in = pkt_dec;
                  if (pkt_dec == 8'd0) begin
                     phase_in = PH_PACKET;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         hidx_ff   <= 5'd0;
         comp_ff   <= 1'b0;
         depth_ff  <= 1'b0;
         width_ff  <= 16'd0;
         height_ff <= 16'd0;
         pl_ff     <= '0;
         pkt_ff    <= 8'd0;
         bip_ff    <= 2'd0;
         asm_ff    <= 32'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         hidx_ff   <= hidx_in;
         comp_ff   <= comp_in;
         depth_ff  <= depth_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         pl_ff     <= pl_in;
         pkt_ff    <= pkt_in;
         bip_ff    <= bip_in;
         asm_ff    <= asm_in;
      end
   end

   a_start_zero_enters_header: assert property (@(posedge clock) disable iff (reset)
      step && beat.frame_start && (beat.data_byte == 8'd0)
      |=> (phase_ff == PH_HEADER) && (hidx_ff == 5'd1))
      else $error("frame start with zero byte did not open the header");

   a_pixel_repeat_range: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && (res.result_kind == KIND_PIXEL)
      |-> (res.repeat_count != 8'd0) && (res.repeat_count <= MAX_RUN))
      else $error("pixel result with repeat outside 1..128");

   a_error_waits: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && (res.result_kind == KIND_ERROR) |=> (phase_ff == PH_WAIT))
      else $error("decoder not waiting after a format error");

endmodule

// ===== hdl/tga_out_reg.sv =====
// result register holding one decoded beat until the receiver takes it
module tga_out_reg
   import tga_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  logic           load_valid,
   input  tga_result_type load_result,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output tga_result_type rsp_result
);

   logic           valid_ff, valid_in;
   tga_result_type result_ff, result_in;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = load_valid;
         result_in = load_result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule
